### src/bpcc_pkg.sv
// bpcc_pkg: shared types and constants of the beacon pulse center capture unit
// no dependencies; imported by the interfaces and every module of the block
package bpcc_pkg;

  localparam int unsigned BEACONS   = 3;
  localparam int unsigned BEACON_W  = 2;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned FOUND_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // beacon codes
  localparam logic [BEACON_W-1:0] BEACON_FIRST = 2'd0;
  localparam logic [BEACON_W-1:0] BEACON_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TURN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP  = 2'd1;

  localparam logic [TIME_W-1:0] MIN_TURN_RST = 16'd40000;
  localparam logic [TIME_W-1:0] MIN_GAP_RST  = 16'd300;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_TAIL,
    ST_EMIT,
    ST_APPLY
  } bpcc_state_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic load;
    logic eval;
    logic scan_clear;
    logic scan_step;
    logic emit;
    logic apply;
  } bpcc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic skip;
    logic closing;
    logic scan_last;
    logic out_free;
  } bpcc_status_t;

endpackage

### src/bpcc_if.sv
// bpcc interfaces: edge request channel, result channel and configuration write channel
// depends on bpcc_pkg for field widths
interface bpcc_edge_if import bpcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BEACON_W-1:0] beacon;
  logic                edge_on;
  logic [TIME_W-1:0]   stamp;

  modport source (output valid, beacon, edge_on, stamp, input ready);
  modport sink   (input valid, beacon, edge_on, stamp, output ready);
endinterface

interface bpcc_result_if import bpcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  slot;
  logic [TIME_W-1:0]  instant_a;
  logic [TIME_W-1:0]  instant_b;
  logic [TIME_W-1:0]  instant_c;
  logic [TIME_W-1:0]  cycle_length;
  logic [FOUND_W-1:0] found_mask;

  modport source (output valid, slot, instant_a, instant_b, instant_c, cycle_length,
                  found_mask, input ready);
  modport sink   (input valid, slot, instant_a, instant_b, instant_c, cycle_length,
                  found_mask, output ready);
endinterface

interface bpcc_cfg_if import bpcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TIME_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/bpcc_ctrl.sv
// bpcc_ctrl: sequencing state machine of the beacon pulse center capture unit
// depends on bpcc_pkg (state enum, command and status structs)
module bpcc_ctrl import bpcc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  bpcc_status_t status_i,
  output bpcc_cmd_t    cmd_o
);

  bpcc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (status_i.skip) begin
          state_d = ST_IDLE;
        end else if (status_i.closing) begin
          cmd_o.scan_clear = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          state_d = ST_APPLY;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_TAIL;
        end
      end
      // last read result is folded into the best trackers here
      ST_TAIL: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### src/bpcc_datapath.sv
// bpcc_datapath: config registers, detection store, best-detection scan and result register
// depends on bpcc_pkg and the bpcc interfaces; driven by bpcc_ctrl commands
module bpcc_datapath import bpcc_pkg::*; #(
  parameter int unsigned SLOTS_PER_BEACON = 4,
  parameter int unsigned HISTORY_DEPTH    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpcc_cfg_if.sink      cfg_i,
  bpcc_edge_if.sink     edge_i,
  bpcc_result_if.source result_o,
  input  bpcc_cmd_t     cmd_i,
  output bpcc_status_t  status_o
);

  localparam int unsigned ENTRIES = BEACONS * SLOTS_PER_BEACON;
  localparam int unsigned AW      = $clog2(ENTRIES);
  localparam int unsigned CW      = (SLOTS_PER_BEACON > 1) ? $clog2(SLOTS_PER_BEACON) : 1;
  localparam int unsigned RW      = $clog2(HISTORY_DEPTH);

  localparam logic [AW-1:0] SLOTS_A  = AW'(SLOTS_PER_BEACON);
  localparam logic [CW-1:0] CUR_LAST = CW'(SLOTS_PER_BEACON - 1);
  localparam logic [RW-1:0] RING_LAST = RW'(HISTORY_DEPTH - 1);
  localparam logic [BEACON_W-1:0] BEACON_LAST = BEACON_W'(BEACONS - 1);

  // configuration
  logic [TIME_W-1:0] min_turn_q, min_gap_q;

  // latched request
  logic [BEACON_W-1:0] item_b_q;
  logic                item_on_q;
  logic [TIME_W-1:0]   item_stamp_q;
  logic [TIME_W-1:0]   rel_q, rel_d;

  // cycle state
  logic [TIME_W-1:0] origin_q;
  logic [RW-1:0]     ring_q, ring_next;
  logic [CW-1:0]     cur_q     [BEACONS];
  logic              ovf_q     [BEACONS];
  logic [TIME_W-1:0] cur_end_q [BEACONS];

  // detection store
  logic [TIME_W-1:0]  start_mem [ENTRIES];
  logic [TIME_W-1:0]  end_mem   [ENTRIES];
  logic [ENTRIES-1:0] start_ok_q, end_ok_q;

  // scan
  logic [BEACON_W-1:0] bcnt_q;
  logic [CW-1:0]       scnt_q;
  logic [AW-1:0]       scan_addr;
  logic                rd_vld_q, rd_ok_q;
  logic [BEACON_W-1:0] rd_b_q;
  logic [TIME_W-1:0]   rd_s_q, rd_e_q;
  logic [TIME_W-1:0]   rd_len;
  logic [TIME_W:0]     rd_sum;
  logic                rd_better;
  logic [TIME_W-1:0]   best_len_q [BEACONS];
  logic [TIME_W-1:0]   best_mid_q [BEACONS];
  logic                have_q     [BEACONS];

  // update of the store
  logic [CW-1:0]     cur_sel;
  logic [AW-1:0]     cur_addr, nxt_addr;
  logic [TIME_W-1:0] gap;
  logic              upd_active;
  logic              wr_start, wr_end, set_ovf, bump_cur;
  logic [AW-1:0]     wr_start_addr;

  // result register
  logic               out_valid_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [TIME_W-1:0]  out_inst_q [BEACONS];
  logic [TIME_W-1:0]  out_len_q;
  logic [FOUND_W-1:0] out_found_q;

  assign cfg_i.ready  = 1'b1;
  assign edge_i.ready = cmd_i.in_ready;

  assign result_o.valid        = out_valid_q;
  assign result_o.slot         = out_slot_q;
  assign result_o.instant_a    = out_inst_q[0];
  assign result_o.instant_b    = out_inst_q[1];
  assign result_o.instant_c    = out_inst_q[2];
  assign result_o.cycle_length = out_len_q;
  assign result_o.found_mask   = out_found_q;

  assign rel_d = item_stamp_q - origin_q;

  assign status_o.in_valid  = edge_i.valid;
  assign status_o.skip      = (item_b_q == BEACON_NONE);
  assign status_o.closing   = item_on_q && (item_b_q == BEACON_FIRST) && (rel_d > min_turn_q);
  assign status_o.scan_last = (bcnt_q == BEACON_LAST) && (scnt_q == CUR_LAST);
  assign status_o.out_free  = !out_valid_q || result_o.ready;

  assign ring_next = (ring_q == RING_LAST) ? '0 : ring_q + 1'b1;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_turn_q <= MIN_TURN_RST;
      min_gap_q  <= MIN_GAP_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_MIN_TURN: min_turn_q <= cfg_i.data;
        REG_MIN_GAP:  min_gap_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_b_q     <= edge_i.beacon;
      item_on_q    <= edge_i.edge_on;
      item_stamp_q <= edge_i.stamp;
    end
    if (cmd_i.eval) begin
      rel_q <= rel_d;
    end else if (cmd_i.emit) begin
      rel_q <= '0;
    end
  end

  // store update for the current request
  always_comb begin
    cur_sel       = cur_q[item_b_q];
    cur_addr      = AW'(item_b_q) * SLOTS_A + AW'(cur_sel);
    nxt_addr      = AW'(item_b_q) * SLOTS_A + AW'(cur_sel + 1'b1);
    gap           = rel_q - cur_end_q[item_b_q];
    upd_active    = cmd_i.apply && !ovf_q[item_b_q];
    wr_start      = 1'b0;
    wr_end        = 1'b0;
    set_ovf       = 1'b0;
    bump_cur      = 1'b0;
    wr_start_addr = cur_addr;
    if (upd_active) begin
      if (item_on_q) begin
        if (end_ok_q[cur_addr]) begin
          if (gap > min_gap_q) begin
            if (cur_sel == CUR_LAST) begin
              set_ovf = 1'b1;
            end else begin
              bump_cur      = 1'b1;
              wr_start      = 1'b1;
              wr_start_addr = nxt_addr;
            end
          end
        end else begin
          // repeated on edge overwrites the open start
          wr_start = 1'b1;
        end
      end else begin
        wr_end = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q   <= '0;
      ring_q     <= '0;
      start_ok_q <= '0;
      end_ok_q   <= '0;
      for (int b = 0; b < BEACONS; b++) begin
        cur_q[b] <= '0;
        ovf_q[b] <= 1'b0;
      end
    end else if (cmd_i.emit) begin
      origin_q   <= item_stamp_q;
      ring_q     <= ring_next;
      start_ok_q <= '0;
      end_ok_q   <= '0;
      for (int b = 0; b < BEACONS; b++) begin
        cur_q[b] <= '0;
        ovf_q[b] <= 1'b0;
      end
    end else begin
      if (wr_start) begin
        start_ok_q[wr_start_addr] <= 1'b1;
      end
      if (wr_end) begin
        end_ok_q[cur_addr] <= 1'b1;
      end
      if (bump_cur) begin
        cur_q[item_b_q] <= cur_sel + 1'b1;
      end
      if (set_ovf) begin
        ovf_q[item_b_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_end) begin
      cur_end_q[item_b_q] <= rel_q;
    end
  end

  // store memories, one write and one registered read each
  assign scan_addr = AW'(bcnt_q) * SLOTS_A + AW'(scnt_q);

  always_ff @(posedge clk_i) begin
    if (wr_start) begin
      start_mem[wr_start_addr] <= rel_q;
    end
    if (wr_end) begin
      end_mem[cur_addr] <= rel_q;
    end
    if (cmd_i.scan_step) begin
      rd_s_q  <= start_mem[scan_addr];
      rd_e_q  <= end_mem[scan_addr];
      rd_ok_q <= start_ok_q[scan_addr] && end_ok_q[scan_addr];
      rd_b_q  <= bcnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q   <= '0;
      scnt_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_step;
      if (cmd_i.scan_clear) begin
        bcnt_q <= '0;
        scnt_q <= '0;
      end else if (cmd_i.scan_step) begin
        if (scnt_q == CUR_LAST) begin
          scnt_q <= '0;
          bcnt_q <= bcnt_q + 1'b1;
        end else begin
          scnt_q <= scnt_q + 1'b1;
        end
      end
    end
  end

  // strictly longer wins, so the lowest slot keeps a tie
  assign rd_len    = rd_e_q - rd_s_q;
  assign rd_sum    = {1'b0, rd_s_q} + {1'b0, rd_e_q};
  assign rd_better = rd_vld_q && rd_ok_q && (rd_len > best_len_q[rd_b_q]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_clear) begin
      for (int b = 0; b < BEACONS; b++) begin
        best_len_q[b] <= '0;
        best_mid_q[b] <= '0;
        have_q[b]     <= 1'b0;
      end
    end else if (rd_better) begin
      best_len_q[rd_b_q] <= rd_len;
      best_mid_q[rd_b_q] <= rd_sum[TIME_W:1];
      have_q[rd_b_q]     <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_slot_q  <= SLOT_W'(ring_next);
      out_len_q   <= rel_q;
      out_found_q <= {have_q[2], have_q[1], have_q[0]};
      for (int b = 0; b < BEACONS; b++) begin
        out_inst_q[b] <= have_q[b] ? best_mid_q[b] : '0;
      end
    end
  end

  a_emit_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || result_o.ready))
    else $error("result written while the previous one is still waiting");

  a_store_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (start_ok_q == '0) && (end_ok_q == '0))
    else $error("store not cleared at cycle close");

  a_read_follows_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(cmd_i.scan_step))
    else $error("scan data valid without a read");

  a_cur_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q[0] <= CUR_LAST) && (cur_q[1] <= CUR_LAST) && (cur_q[2] <= CUR_LAST))
    else $error("current slot past the last slot");

endmodule

### src/beacon_pulse_center_capture_unit.sv
// beacon_pulse_center_capture_unit: top level, joins the controller and the datapath
// depends on bpcc_pkg, bpcc_if, bpcc_ctrl and bpcc_datapath
//
//   channel   | dir | contents
//   ----------+-----+------------------------------------------------------------
//   edge_i    | in  | beacon, edge_on, stamp
//   result_o  | out | slot, instant_a, instant_b, instant_c, cycle_length, found_mask
//   cfg_i     | in  | index (0 min_turn, 1 min_gap), data; always ready
//
// one request at a time: an edge that does not close the cycle is loaded, evaluated and applied;
// beacon 3 is dropped after evaluation; a closing edge also runs the scan, which reads
// one store entry per cycle through the memory read port, then the tail and emit states
// reset clears valid bits, slot counters, origin and ring index at once; no clearing pass
// a waiting result does not block further requests; only a closing edge stalls until it is taken
module beacon_pulse_center_capture_unit import bpcc_pkg::*; #(
  parameter int unsigned SLOTS_PER_BEACON = 4,
  parameter int unsigned HISTORY_DEPTH    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpcc_cfg_if.sink      cfg_i,
  bpcc_edge_if.sink     edge_i,
  bpcc_result_if.source result_o
);

  bpcc_cmd_t    cmd;
  bpcc_status_t status;

  bpcc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  bpcc_datapath #(
    .SLOTS_PER_BEACON (SLOTS_PER_BEACON),
    .HISTORY_DEPTH    (HISTORY_DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .edge_i   (edge_i),
    .result_o (result_o),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule
